// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SITRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SITRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sitrd_pkg.sv
package sitrd_pkg;

  localparam int NUM_WIDTH   = 32;
  localparam int CHAR_WIDTH  = 8;
  localparam int SYM_WIDTH   = 64;
  localparam int RADIX_WIDTH = 5;
  localparam int MAX_BASE    = 16;
  localparam int NUM_SYMS    = 16;
  localparam int NUM_LANES   = 32;
  localparam int DIG_WIDTH   = 4;
  localparam int CNT_WIDTH   = 6;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    CFG_SYM_LOW  = 2'd0,
    CFG_SYM_HIGH = 2'd1,
    CFG_RADIX    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SYM_WIDTH-1:0]   sym_low;
    logic [SYM_WIDTH-1:0]   sym_high;
    logic [RADIX_WIDTH-1:0] radix;
  } alph_t;

  typedef struct packed {
    logic                 neg;
    logic [NUM_WIDTH-1:0] mag;
  } job_t;

  function automatic logic [CHAR_WIDTH-1:0] sym_at(alph_t a, logic [DIG_WIDTH-1:0] idx);
    logic [SYM_WIDTH-1:0] word;
    word = idx[3] ? a.sym_high : a.sym_low;
    return word[{idx[2:0], 3'b000} +: CHAR_WIDTH];
  endfunction

endpackage

// File: rtl/core/sitrd_in_if.sv
interface sitrd_in_if import sitrd_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [NUM_WIDTH-1:0] number_value;

  modport source (output valid, output number_value, input ready);
  modport sink   (input valid, input number_value, output ready);
endinterface

// File: rtl/core/sitrd_out_if.sv
interface sitrd_out_if import sitrd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] out_char;
  logic                  last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// File: rtl/core/sitrd_cfg_if.sv
interface sitrd_cfg_if import sitrd_pkg::*;;
  logic                 valid;
  logic                 ready;
  cfg_idx_t             index;
  logic [SYM_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sitrd_fifo.sv
module sitrd_fifo import sitrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        entry_r[wr_ptr_r] <= push_job;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(pop && pop_valid);
    end
  end

endmodule

// File: rtl/core/sitrd_front.sv
module sitrd_front import sitrd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sitrd_in_if.sink     in_if,
  sitrd_cfg_if.sink    cfg_if,
  output alph_t        alph,
  output logic         push_valid,
  input  logic         push_ready,
  output job_t         push_job
);

  logic [SYM_WIDTH-1:0]   sym_low_r;
  logic [SYM_WIDTH-1:0]   sym_high_r;
  logic [RADIX_WIDTH-1:0] radix_r;
  logic                   alph_ok;
  logic [NUM_WIDTH-1:0]   raw;

  assign cfg_if.ready = 1'b1;
  assign alph = '{sym_low: sym_low_r, sym_high: sym_high_r, radix: radix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r  <= '0;
      sym_high_r <= '0;
      radix_r    <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SYM_LOW:  sym_low_r  <= cfg_if.data;
        CFG_SYM_HIGH: sym_high_r <= cfg_if.data;
        CFG_RADIX:    radix_r    <= cfg_if.data[RADIX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // alphabet check: length in range, no sign symbols, no repeats among symbols in use
  always_comb begin
    logic [CHAR_WIDTH-1:0] s;
    alph_ok = (radix_r >= 5'd2) && (radix_r <= RADIX_WIDTH'(MAX_BASE));
    for (int i = 0; i < NUM_SYMS; i++) begin
      s = sym_at(alph, DIG_WIDTH'(i));
      if (RADIX_WIDTH'(i) < radix_r) begin
        if (s == CHAR_PLUS || s == CHAR_MINUS) alph_ok = 1'b0;
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (RADIX_WIDTH'(j) < radix_r && sym_at(alph, DIG_WIDTH'(j)) == s) alph_ok = 1'b0;
        end
      end
    end
  end

  // a word with a bad alphabet is taken and dropped
  assign in_if.ready  = push_ready;
  assign raw          = in_if.number_value;
  assign push_valid   = in_if.valid && alph_ok;
  assign push_job.neg = raw[NUM_WIDTH-1];
  assign push_job.mag = raw[NUM_WIDTH-1] ? (~raw + 32'd1) : raw;

endmodule

// File: rtl/core/sitrd_back.sv
`include "assert_macros.svh"

module sitrd_back import sitrd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  alph_t       alph,
  input  logic        pop_valid,
  output logic        pop,
  input  job_t        pop_job,
  sitrd_out_if.source out_if
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  localparam logic [4:0] STEP_LAST = 5'(NUM_LANES - 1);

  state_t                 state_r;
  logic [NUM_WIDTH-1:0]   mag_r;
  logic [DIG_WIDTH-1:0]   lane_r   [NUM_LANES];
  logic [DIG_WIDTH-1:0]   lane_nxt [NUM_LANES];
  logic [RADIX_WIDTH-1:0] lane_sum [NUM_LANES];
  logic [CNT_WIDTH-1:0]   ndig_r;
  logic [CNT_WIDTH-1:0]   ndig_nxt;
  logic [4:0]             step_r;
  logic [4:0]             idx_r;
  logic                   sign_pend_r;
  logic                   out_valid_r;
  logic [CHAR_WIDTH-1:0]  out_char_r;
  logic                   out_last_r;
  logic [NUM_LANES-1:0]   gen;
  logic [NUM_LANES-1:0]   prop;
  logic [NUM_LANES:0]     op_a;
  logic [NUM_LANES:0]     op_b;
  logic [NUM_LANES:0]     carry;
  logic [CHAR_WIDTH-1:0]  emit_sym;
  logic                   load_ok;

  assign out_if.valid     = out_valid_r;
  assign out_if.out_char  = out_char_r;
  assign out_if.last_char = out_last_r;

  assign pop      = (state_r == ST_IDLE) && pop_valid;
  assign load_ok  = !out_valid_r || out_if.ready;
  assign emit_sym = sym_at(alph, lane_r[idx_r]);

  // each lane holds one radix digit; shifting in a bit doubles the value.
  // a lane carries out when 2d >= radix (generate) or passes the carry on when 2d+1 == radix,
  // so the carries fall out of one add
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      gen[i]  = ({lane_r[i], 1'b0} >= alph.radix);
      prop[i] = ({lane_r[i], 1'b1} == alph.radix);
    end
    op_a  = {1'b0, gen | prop};
    op_b  = {1'b0, gen};
    carry = (op_a + op_b + (NUM_LANES + 1)'(mag_r[NUM_WIDTH-1])) ^ op_a ^ op_b;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_sum[i] = {lane_r[i], carry[i]};
      lane_nxt[i] = (lane_sum[i] >= alph.radix) ? DIG_WIDTH'(lane_sum[i] - alph.radix)
                                                : DIG_WIDTH'(lane_sum[i]);
    end
    // digit count grows by at most one lane per shifted bit
    ndig_nxt = ndig_r + CNT_WIDTH'(carry[ndig_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      ndig_r      <= 6'd1;
    end else begin
      if (state_r == ST_EMIT && load_ok) out_valid_r <= 1'b1;
      else if (out_if.ready)             out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            mag_r       <= pop_job.mag;
            sign_pend_r <= pop_job.neg;
            ndig_r      <= 6'd1;
            step_r      <= '0;
            for (int i = 0; i < NUM_LANES; i++) lane_r[i] <= '0;
            state_r     <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r  <= {mag_r[NUM_WIDTH-2:0], 1'b0};
          lane_r <= lane_nxt;
          ndig_r <= ndig_nxt;
          step_r <= step_r + 5'd1;
          if (step_r == STEP_LAST) begin
            idx_r   <= 5'(ndig_nxt - 6'd1);
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_ok) begin
            if (sign_pend_r) begin
              out_char_r  <= CHAR_MINUS;
              out_last_r  <= 1'b0;
              sign_pend_r <= 1'b0;
            end else begin
              out_char_r <= emit_sym;
              out_last_r <= (idx_r == 5'd0);
              if (idx_r == 5'd0) state_r <= ST_IDLE;
              else idx_r <= idx_r - 5'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SITRD_ASSERT_IMPL(a_ndig_range, 1'b1, ndig_r != 6'd0 && ndig_r <= 6'(NUM_LANES), "digit count out of range")
  `SITRD_ASSERT_NEXT(a_conv_done, state_r == ST_CONV && step_r == STEP_LAST, state_r == ST_EMIT, "conversion did not end after all bits")
  `SITRD_ASSERT_NEXT(a_last_char, state_r == ST_EMIT && load_ok && !sign_pend_r && idx_r == 5'd0, state_r == ST_IDLE && out_valid_r && out_last_r, "final digit not marked last")

endmodule

// File: rtl/core/signed_integer_to_radix_digits_top.sv
// channel  dir  handshake          word
// in_if    in   valid / ready      number_value (signed 32)
// out_if   out  valid / ready      out_char (8), last_char (1)
// cfg_if   in   valid / ready (=1) index (2), data (64)
//
// a number passes through the back end in order: it is dequeued, its magnitude is shifted
// bit by bit through the radix digit lanes, then its n characters go out at one a cycle while
// out_if is ready (n = sign + digits, at most 33); the next number is dequeued only after
// its last character is loaded; the front takes a word every cycle while its two-entry queue has room
// rst_n is synchronous; configuration clears to zero, digit lanes need no clearing
// a word that meets a bad alphabet is taken and gives no characters
// a stalled out_if holds the back end; the front keeps filling the queue
module signed_integer_to_radix_digits_top import sitrd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sitrd_in_if.sink    in_if,
  sitrd_out_if.source out_if,
  sitrd_cfg_if.sink   cfg_if
);

  alph_t alph;
  logic  push_valid;
  logic  push_ready;
  job_t  push_job;
  logic  pop_valid;
  logic  pop;
  job_t  pop_job;

  sitrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .alph       (alph),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sitrd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  sitrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alph      (alph),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .out_if    (out_if)
  );

endmodule

// File: tb/signed_integer_to_radix_digits_top_test.sv
module signed_integer_to_radix_digits_top_test;
  import sitrd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_GOOD  = 125;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_byte;
    logic                  is_last;
  } char_word_t;

  typedef enum {FROM_TEXT, FROM_PREDICTOR} check_src_t;

  typedef struct {
    logic [SYM_WIDTH-1:0]   lo;
    logic [SYM_WIDTH-1:0]   hi;
    logic [RADIX_WIDTH-1:0] rad;
    logic [NUM_WIDTH-1:0]   value;
    check_src_t             src;
    string                  text;
  } directed_row_t;

  logic clk;
  logic rst_n;

  sitrd_in_if  in_if();
  sitrd_out_if out_if();
  sitrd_cfg_if cfg_if();

  signed_integer_to_radix_digits_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // shadow of the alphabet registers
  logic [SYM_WIDTH-1:0]   sym_low_q;
  logic [SYM_WIDTH-1:0]   sym_high_q;
  logic [RADIX_WIDTH-1:0] radix_q;

  char_word_t    expected_chars[$];
  directed_row_t directed_rows[$];

  int  errors;
  int  numbers_sent;
  int  chars_checked;
  int  alphabets_tried;
  int  bad_alphabets;
  int  cycle_count;
  int  burst_left;
  bit  steady_input;
  bit  hold_req;
  int  hold_left;
  int  holds_done;
  int  rx_cycle;
  int  rx_mode;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters still expected", $time,
               expected_chars.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [CHAR_WIDTH-1:0] symbol_byte(input logic [DIG_WIDTH-1:0] idx);
    logic [SYM_WIDTH-1:0] w;
    w = idx[3] ? sym_high_q : sym_low_q;
    return w[idx[2:0]*8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    int i;
    int j;
    logic [CHAR_WIDTH-1:0] s;
    if (radix_q < 2 || radix_q > MAX_BASE) return 1'b0;
    for (i = 0; i < radix_q; i++) begin
      s = symbol_byte(i[3:0]);
      if (s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (j = i + 1; j < radix_q; j++)
        if (symbol_byte(j[3:0]) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // characters of one number, sign first, then digits most significant first
  function automatic void predict_chars(input logic [NUM_WIDTH-1:0] raw);
    logic [NUM_WIDTH-1:0] mag;
    logic [DIG_WIDTH-1:0] digits[$];
    char_word_t           w;
    int                   i;
    if (!alphabet_valid()) return;
    mag = raw[31] ? (~raw + 32'd1) : raw;
    do begin
      digits.push_front(DIG_WIDTH'(mag % radix_q));
      mag = mag / radix_q;
    end while (mag != 0);
    if (raw[31]) begin
      w.char_byte = CHAR_MINUS;
      w.is_last   = 1'b0;
      expected_chars.push_back(w);
    end
    for (i = 0; i < digits.size(); i++) begin
      w.char_byte = symbol_byte(digits[i]);
      w.is_last   = (i == digits.size() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic void add_row(input logic [SYM_WIDTH-1:0] lo, input logic [SYM_WIDTH-1:0] hi,
                                  input logic [RADIX_WIDTH-1:0] rad,
                                  input logic [NUM_WIDTH-1:0] value,
                                  input check_src_t src, input string text);
    directed_row_t r;
    r.lo    = lo;
    r.hi    = hi;
    r.rad   = rad;
    r.value = value;
    r.src   = src;
    r.text  = text;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(input logic [NUM_WIDTH-1:0] v, input check_src_t src,
                           input string text);
    char_word_t w;
    int i;
    in_if.valid        <= 1'b1;
    in_if.number_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    numbers_sent++;
    if (src == FROM_TEXT) begin
      for (i = 0; i < text.len(); i++) begin
        w.char_byte = text[i];
        w.is_last   = (i == text.len() - 1);
        expected_chars.push_back(w);
      end
    end else begin
      predict_chars(v);
    end
  endtask

  // bursts of words with random gaps between them
  task automatic after_word();
    int gap;
    if (steady_input) return;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a word on a bad alphabet gives nothing, so allow for work still in flight
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [SYM_WIDTH-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_SYM_LOW:  sym_low_q  = d;
      CFG_SYM_HIGH: sym_high_q = d;
      CFG_RADIX:    radix_q    = d[RADIX_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic write_alphabet(input logic [SYM_WIDTH-1:0] lo, input logic [SYM_WIDTH-1:0] hi,
                                input logic [SYM_WIDTH-1:0] radix_word);
    write_reg(CFG_SYM_LOW, lo);
    write_reg(CFG_SYM_HIGH, hi);
    write_reg(CFG_RADIX, radix_word);
    cfg_if.valid <= 1'b0;
    alphabets_tried++;
    if (!alphabet_valid()) bad_alphabets++;
  endtask

  task automatic make_alphabet(input bit allow_bad, output logic [SYM_WIDTH-1:0] lo,
                               output logic [SYM_WIDTH-1:0] hi, output int rad);
    logic [CHAR_WIDTH-1:0] syms[16];
    int  kind;
    int  i;
    int  j;
    bit  clash;
    for (i = 0; i < 16; i++) syms[i] = $urandom_range(0, 255);
    kind = allow_bad ? $urandom_range(0, 9) : 0;
    case ($urandom_range(0, 3))
      0:       rad = 2;
      1:       rad = MAX_BASE;
      default: rad = $urandom_range(2, MAX_BASE);
    endcase
    for (i = 0; i < rad; i++) begin
      do begin
        if ($urandom_range(0, 7) == 0) syms[i] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        else syms[i] = $urandom_range(0, 255);
        clash = (syms[i] == CHAR_PLUS) || (syms[i] == CHAR_MINUS);
        for (j = 0; j < i; j++) if (syms[j] == syms[i]) clash = 1'b1;
      end while (clash);
    end
    case (kind)
      6: rad = $urandom_range(0, 1);
      7: rad = $urandom_range(MAX_BASE + 1, 31);
      8: begin
        i = $urandom_range(0, rad - 2);
        j = $urandom_range(i + 1, rad - 1);
        syms[j] = syms[i];
      end
      9: syms[$urandom_range(0, rad - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      default: ;
    endcase
    for (i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = syms[i];
      hi[i*8 +: 8] = syms[8+i];
    end
  endtask

  function automatic logic [NUM_WIDTH-1:0] pick_value(input int rad);
    logic [NUM_WIDTH-1:0] v;
    logic [NUM_WIDTH-1:0] p;
    int r;
    int k;
    r = (rad < 2) ? 2 : rad;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: begin
        v = $urandom_range(0, r * r);
        if ($urandom_range(0, 1)) v = -v;
      end
      5: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h8000_0000;
          2:       v = 32'h7FFF_FFFF;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      6: begin
        // around a power of the radix
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p <= 32'hFFFF_FFFF / r) begin
          p = p * r;
          k--;
        end
        v = p - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    char_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char, expected none, actual %h last %b", $time,
                 out_if.out_char, out_if.last_char);
      end else begin
        exp_w = expected_chars.pop_front();
        chars_checked++;
        if (out_if.out_char !== exp_w.char_byte) begin
          errors++;
          $display("%0t: out_char mismatch, expected %h, actual %h", $time,
                   exp_w.char_byte, out_if.out_char);
        end
        if (out_if.last_char !== exp_w.is_last) begin
          errors++;
          $display("%0t: last_char mismatch, expected %b, actual %b", $time,
                   exp_w.is_last, out_if.last_char);
        end
      end
    end
  end

  // output side: stall patterns, plus long hold-offs on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req     <= 1'b0;
        hold_left    = HOLD_CYCLES;
        holds_done++;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= $urandom_range(0, 1);
          2:       out_if.ready <= (rx_cycle % 5) < 3;
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [SYM_WIDTH-1:0] lo;
    logic [SYM_WIDTH-1:0] hi;
    logic [SYM_WIDTH-1:0] radix_word;
    int rad;
    int phase;
    int count;
    int k;
    int good_numbers;
    bit hold_phase;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.number_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_SYM_LOW;
    cfg_if.data        = '0;
    hold_req           = 1'b0;
    hold_left          = 0;
    rx_mode            = 0;
    sym_low_q          = '0;
    sym_high_q         = '0;
    radix_q            = '0;
    burst_left         = 1;
    steady_input       = 1'b0;

    // reset alphabet is empty
    add_row(64'h0, 64'h0, 5'd0, 32'd5, FROM_TEXT, "");
    add_row(64'h0, 64'h0, 5'd0, 32'hFFFF_FFFF, FROM_TEXT, "");
    // decimal
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'd0, FROM_TEXT, "0");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'h7FFF_FFFF, FROM_TEXT, "2147483647");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'h8000_0000, FROM_TEXT, "-2147483648");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'hFFFF_FFFF, FROM_TEXT, "-1");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'd9, FROM_TEXT, "9");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'd10, FROM_TEXT, "10");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd10, 32'hEDCB_A988, FROM_PREDICTOR, "");
    // binary, longest output
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd2, 32'h8000_0000, FROM_TEXT,
            {"-1", "0000000000", "0000000000", "0000000000", "0"});
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd2, 32'd1, FROM_TEXT, "1");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd2, 32'h7FFF_FFFF, FROM_PREDICTOR, "");
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd2, 32'hAAAA_AAAA, FROM_PREDICTOR, "");
    // hexadecimal, full alphabet
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd16, 32'h7FFF_FFFF,
            FROM_TEXT, "7FFFFFFF");
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd16, 32'h8000_0000,
            FROM_TEXT, "-80000000");
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd16, 32'hDEAD_BEEF,
            FROM_PREDICTOR, "");
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd16, 32'd15, FROM_TEXT, "F");
    // zero byte as a symbol, signs sitting in unused slots
    add_row(64'h2D2B_2D2B_2D80_FF00, 64'h2B2D, 5'd3, 32'd0, FROM_PREDICTOR, "");
    add_row(64'h2D2B_2D2B_2D80_FF00, 64'h2B2D, 5'd3, 32'hFFFF_FFF9, FROM_PREDICTOR, "");
    add_row(64'h2D2B_2D2B_2D80_FF00, 64'h2B2D, 5'd3, 32'h1234_5678, FROM_PREDICTOR, "");
    // rejected alphabets
    add_row(64'h3736_3534_3332_3130, 64'h3938, 5'd1, 32'd42, FROM_TEXT, "");
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd17, 32'd42, FROM_TEXT, "");
    add_row(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 5'd31, 32'd42, FROM_TEXT, "");
    add_row(64'h3736_3034_3332_3130, 64'h3938, 5'd10, 32'd42, FROM_TEXT, "");
    add_row(64'h3736_3534_3332_3130, 64'h2B45_4443_4241_3938, 5'd16, 32'd42, FROM_TEXT, "");
    add_row(64'h3736_3534_3332_312D, 64'h3938, 5'd2, 32'd42, FROM_TEXT, "");

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].lo != sym_low_q || directed_rows[r].hi != sym_high_q ||
          directed_rows[r].rad != radix_q) begin
        wait_idle();
        write_alphabet(directed_rows[r].lo, directed_rows[r].hi,
                       {59'd0, directed_rows[r].rad});
      end
      send_word(directed_rows[r].value, directed_rows[r].src, directed_rows[r].text);
      after_word();
    end

    good_numbers = 0;
    phase        = 0;
    while (good_numbers < RANDOM_GOOD) begin
      hold_phase = (phase == 1) || (phase == 6);
      make_alphabet(!hold_phase, lo, hi, rad);
      // junk above the radix field is dropped by the register
      radix_word                    = {$urandom, $urandom};
      radix_word[RADIX_WIDTH-1:0]   = rad[RADIX_WIDTH-1:0];
      wait_idle();
      write_alphabet(lo, hi, radix_word);
      steady_input = hold_phase || (phase % 4 == 3);
      if (hold_phase) hold_req <= 1'b1;
      if (!alphabet_valid()) count = $urandom_range(2, 5);
      else if (hold_phase) count = 24;
      else count = $urandom_range(8, 24);
      for (k = 0; k < count; k++) begin
        send_word(pick_value(rad), FROM_PREDICTOR, "");
        if (alphabet_valid()) good_numbers++;
        after_word();
      end
      steady_input = 1'b0;
      phase++;
    end

    wait_idle();
    errors += expected_chars.size();

    $display("sent %0d numbers over %0d alphabet settings, %0d of them rejected",
             numbers_sent, alphabets_tried, bad_alphabets);
    $display("checked %0d characters, output held off %0d times while input kept coming",
             chars_checked, holds_done);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
